[rtl/ogru_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ogru_pkg
// Shared types, constants and helpers of the occupancy grid ray update block.
// ----------------------------------------------------------------------------
package ogru_pkg;

  // input coordinate: signed Q10.8 cells from the map centre
  localparam int IN_W   = 19;
  // grid coordinate, wide enough for every map size up to 4096 cells a side
  localparam int CW     = 13;
  // log-odds cell value, signed Q6.8
  localparam int VW     = 15;
  localparam int FW     = 11;
  localparam int OCC_W  = 14;
  localparam int CFG_W  = 15;
  localparam int IDX_W  = 1;
  localparam int QDEPTH = 2;

  localparam int LOG_ODDS_LIMIT = 12800;

  localparam logic CMD_RAY  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic [IDX_W-1:0] REG_FREE = 1'b0;
  localparam logic [IDX_W-1:0] REG_OCC  = 1'b1;

  localparam logic signed [VW-1:0] FREE_INC_RST = -15'sd104;
  localparam logic [OCC_W-1:0]     OCC_INC_RST  = 14'd562;

  typedef struct packed {
    logic                 cmd;
    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] sy;
    logic signed [CW-1:0] ex;
    logic signed [CW-1:0] ey;
    logic                 ein;
  } item_t;

  function automatic logic in_map(input logic signed [CW-1:0] x,
                                  input logic signed [CW-1:0] y,
                                  input int unsigned size);
    logic [CW:0] lim;
    begin
      lim = (CW+1)'(size);
      in_map = !x[CW-1] && !y[CW-1] && ({1'b0, x} < lim) && ({1'b0, y} < lim);
    end
  endfunction

  function automatic logic signed [VW-1:0] sat_add(input logic signed [VW-1:0] a,
                                                   input logic signed [VW-1:0] b);
    logic signed [VW+1:0] s;
    logic signed [VW+1:0] lim;
    begin
      lim = (VW+2)'(LOG_ODDS_LIMIT);
      s   = {{2{a[VW-1]}}, a} + {{2{b[VW-1]}}, b};
      if (s > lim) begin
        sat_add = lim[VW-1:0];
      end else if (s < -lim) begin
        sat_add = VW'(-lim);
      end else begin
        sat_add = s[VW-1:0];
      end
    end
  endfunction

endpackage
`default_nettype wire

[rtl/ogru_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ogru_front
// Accepts ray and read beats, maps the coordinates to grid cells, flags the
// endpoint as inside or outside and pushes the classified item to the queue.
// ----------------------------------------------------------------------------
module ogru_front #(
  parameter int GRID_DIM = 256
) (
  input  wire                                     in_valid,
  output logic                                    in_stall,
  input  wire                                     in_cmd,
  input  wire logic signed [ogru_pkg::IN_W-1:0]   in_sensor_x,
  input  wire logic signed [ogru_pkg::IN_W-1:0]   in_sensor_y,
  input  wire logic signed [ogru_pkg::IN_W-1:0]   in_end_x,
  input  wire logic signed [ogru_pkg::IN_W-1:0]   in_end_y,
  input  wire                                     q_full,
  input  wire                                     clearing,
  output logic                                    push,
  output ogru_pkg::item_t                         push_item
);
  import ogru_pkg::*;

  localparam int GW   = CW + 8;
  localparam int BIAS = GRID_DIM * 128;

  function automatic logic signed [CW-1:0] to_grid(input logic signed [IN_W-1:0] f);
    logic signed [GW-1:0] v;
    begin
      v       = {{(GW-IN_W){f[IN_W-1]}}, f} + GW'(BIAS);
      to_grid = v[GW-1:8];
    end
  endfunction

  logic signed [CW-1:0] ex, ey;

  assign ex = to_grid(in_end_x);
  assign ey = to_grid(in_end_y);

  assign in_stall = q_full || clearing;
  assign push     = in_valid && !in_stall;

  always_comb begin
    push_item.cmd = in_cmd;
    push_item.sx  = to_grid(in_sensor_x);
    push_item.sy  = to_grid(in_sensor_y);
    push_item.ex  = ex;
    push_item.ey  = ey;
    push_item.ein = in_map(ex, ey, GRID_DIM);
  end

endmodule
`default_nettype wire

[rtl/ogru_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ogru_queue
// Short FIFO of classified items between the front and the ray walker.
// ----------------------------------------------------------------------------
module ogru_queue (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              push,
  input  wire ogru_pkg::item_t push_item,
  input  wire              pop,
  output ogru_pkg::item_t  pop_item,
  output logic             not_empty,
  output logic             full
);
  import ogru_pkg::*;

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int NW = $clog2(QDEPTH + 1);

  item_t           q_r [QDEPTH];
  logic [PW-1:0]   wptr_r, rptr_r;
  logic [NW-1:0]   cnt_r, cnt_nxt;

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    begin
      bump = (p == PW'(QDEPTH - 1)) ? '0 : p + PW'(1);
    end
  endfunction

  assign not_empty = (cnt_r != '0);
  assign full      = (cnt_r == NW'(QDEPTH));
  assign pop_item  = q_r[rptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + NW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wptr_r <= bump(wptr_r);
      end
      if (pop) begin
        rptr_r <= bump(rptr_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wptr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

[rtl/ogru_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ogru_back
// Grid memory and ray walker: clears the grid after reset, walks the line one
// cell per cycle with a read-modify-write pipeline and returns one result
// beat per item through an output register.
// ----------------------------------------------------------------------------
module ogru_back #(
  parameter int GRID_DIM = 256
) (
  input  wire                                     clk,
  input  wire                                     rst_n,
  input  wire                                     q_valid,
  input  wire ogru_pkg::item_t                    q_item,
  output logic                                    q_pop,
  output logic                                    clearing,
  input  wire logic signed [ogru_pkg::VW-1:0]     free_inc,
  input  wire logic [ogru_pkg::OCC_W-1:0]         occ_inc,
  output logic                                    out_valid,
  input  wire                                     out_stall,
  output logic signed [ogru_pkg::VW-1:0]          out_read_value,
  output logic [ogru_pkg::FW-1:0]                 out_cells_freed,
  output logic                                    out_endpoint_inside
);
  import ogru_pkg::*;

  localparam int CELLS = GRID_DIM * GRID_DIM;
  localparam int AW    = $clog2(CELLS);
  localparam int EW    = CW + 3;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_LOAD  = 5'b00100,
    S_WALK  = 5'b01000,
    S_FIN   = 5'b10000
  } state_t;

  state_t                state_r, state_nxt;
  logic [AW-1:0]         clr_cnt_r;
  item_t                 cur_r;
  logic signed [CW-1:0]  cx_r, cy_r, dx_r, dy_r;
  logic                  stx_r, sty_r;
  logic signed [EW-1:0]  err_r;
  logic [FW-1:0]         freed_r;

  logic                  pw_v_r;
  logic [AW-1:0]         pw_addr_r;
  logic signed [VW-1:0]  pw_inc_r;

  logic [VW-1:0]         mem [CELLS];
  logic signed [VW-1:0]  rd_data_r;

  logic                  rd_en, wr_en;
  logic [AW-1:0]         rd_addr, wr_addr;
  logic [VW-1:0]         wr_data;

  logic signed [CW-1:0]  ex_s, ey_s, adx, ady;
  logic                  at_end, cin, c1, c2, out_free;
  logic signed [EW:0]    e2;
  logic [2*CW-1:0]       lin;
  logic signed [VW-1:0]  occ_s;

  assign ex_s     = cur_r.ex;
  assign ey_s     = cur_r.ey;
  assign at_end   = (cx_r == ex_s) && (cy_r == ey_s);
  assign cin      = in_map(cx_r, cy_r, GRID_DIM);
  assign e2       = {err_r, 1'b0};
  assign c1       = e2 > -(EW+1)'(dy_r);
  assign c2       = e2 < (EW+1)'(dx_r);
  assign lin      = (2*CW)'($unsigned(cy_r)) * (2*CW)'(GRID_DIM) + (2*CW)'($unsigned(cx_r));
  assign occ_s    = {1'b0, occ_inc};
  assign out_free = !out_valid || !out_stall;
  assign adx      = (ex_s > cx_r) ? ex_s - cx_r : cx_r - ex_s;
  assign ady      = (ey_s > cy_r) ? ey_s - cy_r : cy_r - ey_s;

  assign clearing = (state_r == S_CLEAR);
  assign q_pop    = (state_r == S_IDLE) && q_valid;
  assign rd_addr  = lin[AW-1:0];
  assign rd_en    = (state_r == S_WALK) && (at_end ? cur_r.ein : cin);

  always_comb begin
    if (state_r == S_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt_r;
      wr_data = '0;
    end else begin
      wr_en   = pw_v_r;
      wr_addr = pw_addr_r;
      wr_data = sat_add(rd_data_r, pw_inc_r);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (clr_cnt_r == AW'(CELLS - 1)) state_nxt = S_IDLE;
      S_IDLE:  if (q_valid) state_nxt = S_LOAD;
      S_LOAD:  state_nxt = S_WALK;
      S_WALK:  if (at_end) state_nxt = S_FIN;
      S_FIN:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_cnt_r <= '0;
      pw_v_r    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pw_v_r  <= rd_en && (cur_r.cmd == CMD_RAY);
      if (state_r == S_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
      end
      if (state_r == S_FIN && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pw_addr_r <= rd_addr;
    pw_inc_r  <= at_end ? occ_s : free_inc;
    unique case (state_r)
      S_IDLE: begin
        cur_r   <= q_item;
        freed_r <= '0;
        if (q_item.cmd == CMD_READ) begin
          cx_r <= q_item.ex;
          cy_r <= q_item.ey;
        end else begin
          cx_r <= q_item.sx;
          cy_r <= q_item.sy;
        end
      end
      S_LOAD: begin
        dx_r  <= adx;
        dy_r  <= ady;
        stx_r <= cx_r < ex_s;
        sty_r <= cy_r < ey_s;
        err_r <= EW'(adx) - EW'(ady);
      end
      S_WALK: begin
        if (!at_end) begin
          if (cin && freed_r != '1) begin
            freed_r <= freed_r + FW'(1);
          end
          if (c1) begin
            cx_r <= stx_r ? cx_r + CW'(1) : cx_r - CW'(1);
          end
          if (c2) begin
            cy_r <= sty_r ? cy_r + CW'(1) : cy_r - CW'(1);
          end
          err_r <= err_r - (c1 ? EW'(dy_r) : '0) + (c2 ? EW'(dx_r) : '0);
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_read_value      <= (cur_r.cmd == CMD_READ && cur_r.ein) ? rd_data_r : '0;
          out_cells_freed     <= freed_r;
          out_endpoint_inside <= cur_r.ein;
        end
      end
      S_CLEAR: begin
      end
      default: begin
      end
    endcase
  end

  a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && rd_en) |-> (wr_addr != rd_addr))
    else $error("grid read and write hit the same cell");

  a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !q_pop)
    else $error("item taken during clearing pass");

  a_read_frees_nothing: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && cur_r.cmd == CMD_READ) |-> (freed_r == '0))
    else $error("read item counted freed cells");

  a_write_in_ray: assert property (@(posedge clk) disable iff (!rst_n)
    pw_v_r |-> (state_r == S_WALK || state_r == S_FIN))
    else $error("cell write outside a ray walk");

endmodule
`default_nettype wire

[rtl/occupancy_grid_ray_update.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// occupancy_grid_ray_update
// Log-odds occupancy grid updated along Bresenham rays, with single cell reads.
// ----------------------------------------------------------------------------
// ray beat: leaves the queue in idle, passes the load, walk and finish states
// to the registered result; read beat: walk stops at once on the endpoint;
// a ray walk does one read-modify-write per cycle on the single write port for
// each cell inside the map; one item is walked at a time, and a two-entry queue
// lets the front take beats while the walker is busy; after reset the grid
// is swept to zero with in_stall high; config writes are taken during the sweep
module occupancy_grid_ray_update #(
  parameter int GRID_DIM = 256
) (
  input  wire                                     clk,
  input  wire                                     rst_n,
  input  wire                                     in_valid,
  output logic                                    in_stall,
  input  wire                                     in_cmd,
  input  wire logic signed [ogru_pkg::IN_W-1:0]   in_sensor_x,
  input  wire logic signed [ogru_pkg::IN_W-1:0]   in_sensor_y,
  input  wire logic signed [ogru_pkg::IN_W-1:0]   in_end_x,
  input  wire logic signed [ogru_pkg::IN_W-1:0]   in_end_y,
  output logic                                    out_valid,
  input  wire                                     out_stall,
  output logic signed [ogru_pkg::VW-1:0]          out_read_value,
  output logic [ogru_pkg::FW-1:0]                 out_cells_freed,
  output logic                                    out_endpoint_inside,
  input  wire                                     cfg_we,
  input  wire logic [ogru_pkg::IDX_W-1:0]         cfg_index,
  input  wire logic [ogru_pkg::CFG_W-1:0]         cfg_wdata
);
  import ogru_pkg::*;

  logic signed [VW-1:0] free_inc_r;
  logic [OCC_W-1:0]     occ_inc_r;
  logic                 push, pop, q_ne, q_full, clearing;
  item_t                push_item, pop_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_inc_r <= FREE_INC_RST;
      occ_inc_r  <= OCC_INC_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FREE: free_inc_r <= cfg_wdata[VW-1:0];
        REG_OCC:  occ_inc_r  <= cfg_wdata[OCC_W-1:0];
        default:  begin
        end
      endcase
    end
  end

  ogru_front #(.GRID_DIM(GRID_DIM)) u_front (
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_cmd      (in_cmd),
    .in_sensor_x (in_sensor_x),
    .in_sensor_y (in_sensor_y),
    .in_end_x    (in_end_x),
    .in_end_y    (in_end_y),
    .q_full      (q_full),
    .clearing    (clearing),
    .push        (push),
    .push_item   (push_item)
  );

  ogru_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .not_empty (q_ne),
    .full      (q_full)
  );

  ogru_back #(.GRID_DIM(GRID_DIM)) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_valid             (q_ne),
    .q_item              (pop_item),
    .q_pop               (pop),
    .clearing            (clearing),
    .free_inc            (free_inc_r),
    .occ_inc             (occ_inc_r),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_read_value      (out_read_value),
    .out_cells_freed     (out_cells_freed),
    .out_endpoint_inside (out_endpoint_inside)
  );

endmodule
`default_nettype wire
